### hdl/swq_pkg.sv
// swq_pkg: shared constants and types of the sleep/wake-up timer queue.
// No dependencies; imported by the queue top, its checker and the testbench.
package swq_pkg;

    // Queue depth and the widths that follow from it
    localparam int QUEUE_ENTRIES = 16;
    localparam int IDX_W = (QUEUE_ENTRIES > 1) ? $clog2(QUEUE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(QUEUE_ENTRIES + 1);

    // Payload field widths
    localparam int ID_W   = 8;
    localparam int TICK_W = 63;
    localparam int SLOT_W = ID_W + TICK_W;
    localparam int DATA_W = ((ID_W + TICK_W + 7) / 8) * 8;

    // Largest wake tick, also the "queue empty" marker
    localparam logic [TICK_W-1:0] TICK_ONES  = {TICK_W{1'b1}};
    localparam logic [CNT_W-1:0]  QUEUE_FULL = CNT_W'(QUEUE_ENTRIES);
    localparam logic [CNT_W-1:0]  CNT_ONE    = CNT_W'(1);

    // Function codes on the input tuser
    localparam logic FUNC_SLEEP = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef logic [TICK_W-1:0] tick_t;
    typedef logic [ID_W-1:0]   id_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // One queue slot as stored in the slot memory
    typedef struct packed {
        id_t   id;
        tick_t tick;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } state_t;

endpackage

### hdl/swq_ram.sv
// swq_ram: simple dual-port synchronous RAM, one write and one registered read port.
// Generic; used for the slot store and the woken-id buffer.
module swq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered: data valid in the cycle after re, held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/sleep_wakeup_timer_queue.sv
// Sleep/wake-up timer queue. A sleep transaction (tuser = 0) appends an entry id with its
// wake tick and answers with one registered result, or flags full_error when all
// QUEUE_ENTRIES slots are taken. A tick transaction (tuser = 1) carries the current time:
// the slot memory is scanned once, one entry per cycle through its single read port;
// expired entries go to a woken buffer in insertion order, survivors are compacted in
// place and the earliest pending wake tick is recomputed (all ones when empty). Each
// woken result is then read from the buffer and loaded into the output register, which
// waits while the output stalls; one plain result leaves when nothing expired. Every
// result carries next_wake as it stands after the item; tlast marks the item's final
// result. Items are handled one at a time; no memory clearing is needed after reset.
// Depends on swq_pkg and swq_ram.
module sleep_wakeup_timer_queue
    import swq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // entry_id[7:0], tick_value[70:8], zero pad
    input  logic              s_tuser,   // func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // woken_id[7:0], next_wake[70:8], zero pad
    output logic [1:0]        m_tuser,   // woken_valid, full_error
    output logic              m_tlast
);

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    tick_t  earliest_reg, earliest_next;
    tick_t  now_reg, now_next;
    cnt_t   rd_idx_reg, rd_idx_next;
    logic   pend_reg, pend_next;
    cnt_t   keep_reg, keep_next;
    cnt_t   nw_reg, nw_next;
    tick_t  minw_reg, minw_next;
    cnt_t   emit_idx_reg, emit_idx_next;

    // Output register
    logic   m_valid_reg, m_valid_next;
    logic   out_woken_reg, out_woken_next;
    id_t    out_id_reg, out_id_next;
    tick_t  out_wake_reg, out_wake_next;
    logic   out_err_reg, out_err_next;
    logic   out_last_reg, out_last_next;

    // Memory ports
    logic   slot_we, slot_re;
    idx_t   slot_waddr, slot_raddr;
    slot_t  slot_wdata, slot_rdata;
    logic   wbuf_we, wbuf_re;
    idx_t   wbuf_waddr, wbuf_raddr;
    id_t    wbuf_wdata, wbuf_rdata;

    logic   out_free;
    logic   in_acc;
    id_t    in_id;
    tick_t  in_tick;
    tick_t  sleep_min;

    assign in_id   = s_tdata[ID_W-1:0];
    assign in_tick = s_tdata[ID_W+TICK_W-1:ID_W];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign sleep_min = (in_tick < earliest_reg) ? in_tick : earliest_reg;

    // Slot store: id and wake tick of each queued entry
    swq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_ENTRIES)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Woken-id buffer, filled during a scan and drained afterwards
    swq_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_ENTRIES)
    ) u_wbuf_ram (
        .aclk  (aclk),
        .we    (wbuf_we),
        .waddr (wbuf_waddr),
        .wdata (wbuf_wdata),
        .re    (wbuf_re),
        .raddr (wbuf_raddr),
        .rdata (wbuf_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_tuser == FUNC_TICK) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_idx_reg == count_reg && !pend_reg) begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                if (nw_reg == '0) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_EMIT_WAIT;
                end
            end
            ST_EMIT_WAIT: begin
                if (out_free) begin
                    if (emit_idx_reg + CNT_ONE == nw_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory control and output loading
    always_comb begin
        count_next    = count_reg;
        earliest_next = earliest_reg;
        now_next      = now_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        keep_next     = keep_reg;
        nw_next       = nw_reg;
        minw_next     = minw_reg;
        emit_idx_next = emit_idx_reg;

        m_valid_next   = m_valid_reg && !m_tready;
        out_woken_next = out_woken_reg;
        out_id_next    = out_id_reg;
        out_wake_next  = out_wake_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;

        slot_we    = 1'b0;
        slot_waddr = count_reg[IDX_W-1:0];
        slot_wdata = '{id: in_id, tick: in_tick};
        slot_re    = 1'b0;
        slot_raddr = rd_idx_reg[IDX_W-1:0];
        wbuf_we    = 1'b0;
        wbuf_waddr = nw_reg[IDX_W-1:0];
        wbuf_wdata = slot_rdata.id;
        wbuf_re    = 1'b0;
        wbuf_raddr = emit_idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser == FUNC_SLEEP) begin
                        m_valid_next   = 1'b1;
                        out_woken_next = 1'b0;
                        out_id_next    = '0;
                        out_last_next  = 1'b1;
                        if (count_reg == QUEUE_FULL) begin
                            // rejected sleep leaves the queue alone
                            out_err_next  = 1'b1;
                            out_wake_next = earliest_reg;
                        end else begin
                            slot_we       = 1'b1;
                            count_next    = count_reg + CNT_ONE;
                            earliest_next = sleep_min;
                            out_err_next  = 1'b0;
                            out_wake_next = sleep_min;
                        end
                    end else begin
                        now_next      = in_tick;
                        rd_idx_next   = '0;
                        pend_next     = 1'b0;
                        keep_next     = '0;
                        nw_next       = '0;
                        minw_next     = TICK_ONES;
                        emit_idx_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                // issue the next read
                if (rd_idx_reg != count_reg) begin
                    slot_re     = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_ONE;
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                // classify the entry read last cycle; compaction writes trail the reads
                if (pend_reg) begin
                    if (slot_rdata.tick <= now_reg) begin
                        wbuf_we = 1'b1;
                        nw_next = nw_reg + CNT_ONE;
                    end else begin
                        slot_we    = 1'b1;
                        slot_waddr = keep_reg[IDX_W-1:0];
                        slot_wdata = slot_rdata;
                        keep_next  = keep_reg + CNT_ONE;
                        if (slot_rdata.tick < minw_reg) begin
                            minw_next = slot_rdata.tick;
                        end
                    end
                end
                // scan done: commit survivors and the new minimum
                if (rd_idx_reg == count_reg && !pend_reg) begin
                    count_next    = keep_reg;
                    earliest_next = minw_reg;
                end
            end
            ST_EMIT_RD: begin
                if (nw_reg == '0) begin
                    if (out_free) begin
                        m_valid_next   = 1'b1;
                        out_woken_next = 1'b0;
                        out_id_next    = '0;
                        out_wake_next  = earliest_reg;
                        out_err_next   = 1'b0;
                        out_last_next  = 1'b1;
                    end
                end else begin
                    wbuf_re = 1'b1;
                end
            end
            ST_EMIT_WAIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_woken_next = 1'b1;
                    out_id_next    = wbuf_rdata;
                    out_wake_next  = earliest_reg;
                    out_err_next   = 1'b0;
                    out_last_next  = (emit_idx_reg + CNT_ONE == nw_reg);
                    emit_idx_next  = emit_idx_reg + CNT_ONE;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            earliest_reg <= TICK_ONES;
            m_valid_reg  <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            earliest_reg <= earliest_next;
            m_valid_reg  <= m_valid_next;
            pend_reg     <= pend_next;
        end
    end

    // Scan working registers and output payload
    always_ff @(posedge aclk) begin
        now_reg       <= now_next;
        rd_idx_reg    <= rd_idx_next;
        keep_reg      <= keep_next;
        nw_reg        <= nw_next;
        minw_reg      <= minw_next;
        emit_idx_reg  <= emit_idx_next;
        out_woken_reg <= out_woken_next;
        out_id_reg    <= out_id_next;
        out_wake_reg  <= out_wake_next;
        out_err_reg   <= out_err_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(DATA_W - ID_W - TICK_W){1'b0}}, out_wake_reg, out_id_reg};
    assign m_tuser  = {out_err_reg, out_woken_reg};
    assign m_tlast  = out_last_reg;

endmodule

### hdl/swq_checker.sv
// swq_checker: port-level assertions for the sleep/wake-up timer queue, bound to the top.
// Depends on swq_pkg.
module swq_checker
    import swq_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [1:0]        m_tuser,
    input logic              m_tlast
);

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // A rejected sleep is a single, non-woken result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("full_error result not alone");

    // A result without a woken entry always ends its transaction, with a zero id
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[ID_W-1:0] == '0)
        else $error("non-woken result not final or id nonzero");

    // Woken results of one tick share one next_wake
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[0] && !m_tlast ##1 m_tvalid[*1]
            |-> m_tdata[ID_W+TICK_W-1:ID_W] == $past(m_tdata[ID_W+TICK_W-1:ID_W]))
        else $error("next_wake changed within a tick");

    // Nothing is presented right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sleep_wakeup_timer_queue swq_checker u_swq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/sv/tb_sleep_wakeup_timer_queue.sv
// Self-checking testbench of sleep_wakeup_timer_queue: sleep and tick transactions in,
// woken-entry results out, checked against a cycle-free model of the queue.
// Depends on swq_pkg and the sleep_wakeup_timer_queue RTL.
module tb_sleep_wakeup_timer_queue;
    import swq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;

    // One result transaction as seen on the master side
    typedef struct packed {
        logic  woken_valid;
        id_t   woken_id;
        tick_t next_wake;
        logic  full_error;
        logic  last;
    } wake_result_t;

    // Queue model plus the FIFO of results it predicts
    class wake_scoreboard;
        id_t          slot_id[QUEUE_ENTRIES];
        tick_t        slot_tick[QUEUE_ENTRIES];
        int unsigned  occupied;
        tick_t        earliest;
        wake_result_t expected_wakes[$];
        int           errors;

        function new();
            occupied = 0;
            earliest = TICK_ONES;
            errors   = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Predict the results of one accepted input transaction
        function void predict_wakeups(logic func, id_t id, tick_t tv);
            wake_result_t r;
            id_t          woken[$];
            int unsigned  keep;
            tick_t        min_tick;
            r = '0;
            keep = 0;
            min_tick = TICK_ONES;
            if (func == FUNC_SLEEP) begin
                if (occupied >= QUEUE_ENTRIES) begin
                    r.full_error = 1'b1;
                end else begin
                    slot_id[occupied]   = id;
                    slot_tick[occupied] = tv;
                    occupied++;
                    if (tv < earliest)
                        earliest = tv;
                end
                r.next_wake = earliest;
                r.last = 1'b1;
                expected_wakes.push_back(r);
            end else begin
                // wake expired entries in order, compact the survivors
                for (int i = 0; i < occupied; i++) begin
                    if (slot_tick[i] <= tv) begin
                        woken.push_back(slot_id[i]);
                    end else begin
                        if (slot_tick[i] < min_tick)
                            min_tick = slot_tick[i];
                        slot_id[keep]   = slot_id[i];
                        slot_tick[keep] = slot_tick[i];
                        keep++;
                    end
                end
                occupied = keep;
                earliest = min_tick;
                r.next_wake = earliest;
                if (woken.size() == 0) begin
                    r.last = 1'b1;
                    expected_wakes.push_back(r);
                end else begin
                    foreach (woken[k]) begin
                        r.woken_valid = 1'b1;
                        r.woken_id    = woken[k];
                        r.last        = (k == woken.size() - 1);
                        expected_wakes.push_back(r);
                    end
                end
            end
        endfunction

        // Compare one accepted result with the oldest prediction
        task check_result(wake_result_t got);
            wake_result_t want;
            if (expected_wakes.size() == 0) begin
                report($sformatf("unexpected result id=%0d next=%0h", got.woken_id,
                                 got.next_wake));
            end else begin
                want = expected_wakes.pop_front();
                if (got.woken_valid !== want.woken_valid)
                    report($sformatf("woken_valid got %b want %b", got.woken_valid,
                                     want.woken_valid));
                if (got.woken_id !== want.woken_id)
                    report($sformatf("woken_id got %0d want %0d", got.woken_id,
                                     want.woken_id));
                if (got.next_wake !== want.next_wake)
                    report($sformatf("next_wake got %0h want %0h", got.next_wake,
                                     want.next_wake));
                if (got.full_error !== want.full_error)
                    report($sformatf("full_error got %b want %b", got.full_error,
                                     want.full_error));
                if (got.last !== want.last)
                    report($sformatf("tlast got %b want %b", got.last, want.last));
            end
        endtask
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;   // entry_id[7:0], tick_value[70:8], zero pad
    logic              s_tuser  = 1'b0; // func
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // woken_id[7:0], next_wake[70:8], zero pad
    logic [1:0]        m_tuser;         // woken_valid, full_error
    logic              m_tlast;

    wake_scoreboard sb;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             cycle_count = 0;
    tick_t          wall_clock = '0;

    sleep_wakeup_timer_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Timeout guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: results first, then the new input, so FIFO order holds
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result({m_tuser[0], m_tdata[ID_W-1:0], m_tdata[ID_W +: TICK_W],
                                 m_tuser[1], m_tlast});
            if (s_tvalid && s_tready)
                sb.predict_wakeups(s_tuser, s_tdata[ID_W-1:0], s_tdata[ID_W +: TICK_W]);
        end
    end

    function automatic tick_t random_tick();
        return tick_t'({$urandom, $urandom});
    endfunction

    // Offer one transaction, with random idle cycles ahead of it; returns at a falling edge
    task automatic push_item(logic func, id_t id, tick_t tv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(DATA_W-SLOT_W){1'b0}}, tv, id};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly well-formed traffic around a moving clock, some full-range noise
    task automatic run_random_phase(int n_items, int sleep_pct);
        tick_t tv;
        wall_clock = random_tick() >> $urandom_range(0, 62);
        repeat (n_items) begin
            if ($urandom_range(99) < sleep_pct) begin
                if ($urandom_range(99) < 15)
                    tv = random_tick();
                else
                    tv = wall_clock + $urandom_range(0, 40);
                push_item(FUNC_SLEEP, id_t'($urandom_range(255)), tv);
            end else begin
                if ($urandom_range(99) < 10) begin
                    tv = random_tick();
                end else begin
                    wall_clock = wall_clock + $urandom_range(0, 30);
                    tv = wall_clock;
                end
                push_item(FUNC_TICK, id_t'($urandom_range(255)), tv);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty tick, field extremes, no-wake tick, fill, overflow, drain
        push_item(FUNC_TICK, 8'd0, '0);
        push_item(FUNC_SLEEP, 8'd0, '0);
        push_item(FUNC_SLEEP, 8'd255, TICK_ONES);
        push_item(FUNC_SLEEP, 8'hA5, tick_t'(5));
        push_item(FUNC_TICK, 8'd255, '0);
        push_item(FUNC_TICK, 8'd0, tick_t'(4));
        push_item(FUNC_TICK, 8'd0, TICK_ONES - 1);
        for (int i = 0; i < QUEUE_ENTRIES - 1; i++)
            push_item(FUNC_SLEEP, id_t'(i % 4), tick_t'(i * 3 + 7));
        push_item(FUNC_SLEEP, 8'h5A, '0);
        push_item(FUNC_TICK, 8'd0, TICK_ONES);
        push_item(FUNC_TICK, 8'd0, TICK_ONES);

        // Random phases: no idling, sender idle, receiver stall, both
        run_random_phase(31, 60);
        send_idle_pct = 58;
        run_random_phase(31, 75);
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        run_random_phase(31, 50);
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        run_random_phase(31, 70);
        s_tvalid <= 1'b0;

        // Drain
        while (sb.expected_wakes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
